@@ sv/alle_pkg.sv @@
// Shared types, constants and helpers for the array linked list engine.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package alle_pkg;

    localparam int NODE_COUNT = 64;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_W     = 7;                    // node address, 0 is nil
    localparam int IDX_W      = $clog2(NODE_COUNT);   // memory row index
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_DEL_HEAD = 3'd2,
        CMD_DEL_TAIL = 3'd3,
        CMD_SEARCH   = 3'd4,
        CMD_PRED     = 3'd5,
        CMD_MEMBER   = 3'd6
    } cmd_code_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [VALUE_BITS-1:0] data_value;
        logic [ADDR_W-1:0]     node_address;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [VALUE_BITS-1:0] value_out;
        logic [ADDR_W-1:0]     address_out;
    } rsp_item_t;

    // node address (1..NODE_COUNT) to memory row
    function automatic logic [IDX_W-1:0] to_idx(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] t;
        t = a - ADDR_W'(1);
        return t[IDX_W-1:0];
    endfunction

    // link of a row never written: next node, last row points to nil
    function automatic logic [ADDR_W-1:0] link_init(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] r;
        if (idx == IDX_W'(NODE_COUNT - 1))
        begin
            r = '0;
        end
        else
        begin
            r = ADDR_W'(idx) + ADDR_W'(2);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/array_linked_list_engine_top.sv @@
// Top level of the array linked list engine: FSM, link and value memories.
// Depends on alle_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                        | Carries
// ---------+--------------------------------+-------------------------------------
// cmd      | cmd_valid, cmd_ready, cmd_item | command, data_value, node_address
// rsp      | rsp_valid, rsp_ready, rsp_item | status, value_out, address_out
//
// One command is worked at a time. Head insert pops the free list, then links the
// new node in; head delete reads the old head, then frees it. Walks visit one node
// per cycle through the single read port of the link memory: tail insert and tail
// delete walk the whole list, search and member test stop at the first match.
// A new command transfers while the previous result waits in the output register.
// Reset (rst_n, async) empties the list, puts all nodes on the free list and
// marks every link row unwritten; no clearing pass is needed.
// A stalled rsp side holds the finished result in the FSM until the output
// register frees.

module array_linked_list_engine_top
    import alle_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_item_t cmd_item,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp_item
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_START      = 7'b0000010,
        S_ALLOC_WAIT = 7'b0000100,
        S_WALK       = 7'b0001000,
        S_DHEAD_WAIT = 7'b0010000,
        S_FREE       = 7'b0100000,
        S_DONE       = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // captured command
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0] x_reg, x_next;
    logic [ADDR_W-1:0]     taddr_reg, taddr_next;

    // list registers
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] free_reg, free_next;
    logic [ADDR_W-1:0] p_reg, p_next;     // current node of a walk
    logic [ADDR_W-1:0] q_reg, q_next;     // its predecessor
    logic [ADDR_W-1:0] new_reg, new_next; // node taken by an insert

    rsp_item_t res_reg, res_next;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_item_reg, rsp_item_next;

    // memories
    logic [ADDR_W-1:0]     link_mem [NODE_COUNT];
    logic [VALUE_BITS-1:0] val_mem  [NODE_COUNT];
    logic [NODE_COUNT-1:0] link_written_reg;

    logic                  lnk_we;
    logic [IDX_W-1:0]      lnk_widx;
    logic [ADDR_W-1:0]     lnk_wdata;
    logic                  val_we;
    logic [IDX_W-1:0]      val_widx;
    logic [VALUE_BITS-1:0] val_wdata;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;

    logic [ADDR_W-1:0]     link_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     lnk;

    // Both memories share one read index; only an insert writes the row read in the
    // same cycle, into the value memory, whose read is then unused.
    always_ff @(posedge clk)
    begin
        if (lnk_we)
        begin
            link_mem[lnk_widx] <= lnk_wdata;
        end
        if (val_we)
        begin
            val_mem[val_widx] <= val_wdata;
        end
        if (rd_en)
        begin
            link_rd_reg  <= link_mem[rd_idx];
            val_rd_reg   <= val_mem[rd_idx];
            rd_idx_reg   <= rd_idx;
            rd_valid_reg <= link_written_reg[rd_idx];
        end
    end

    // Rows not yet written read as their reset link.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_written_reg <= '0;
        end
        else if (lnk_we)
        begin
            link_written_reg[lnk_widx] <= 1'b1;
        end
    end

    assign lnk = rd_valid_reg ? link_rd_reg : link_init(rd_idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        taddr_next     = taddr_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        lnk_we    = 1'b0;
        lnk_widx  = '0;
        lnk_wdata = '0;
        val_we    = 1'b0;
        val_widx  = '0;
        val_wdata = '0;
        rd_en     = 1'b0;
        rd_idx    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd_item.command;
                    x_next     = cmd_item.data_value;
                    taddr_next = cmd_item.node_address;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_next   = '{status: ST_MISS, value_out: '0, address_out: '0};
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_INS_HEAD, CMD_INS_TAIL:
                    begin
                        if (free_reg == '0)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            // pop the free list; value goes in now
                            new_next   = free_reg;
                            rd_en      = 1'b1;
                            rd_idx     = to_idx(free_reg);
                            val_we     = 1'b1;
                            val_widx   = to_idx(free_reg);
                            val_wdata  = x_reg;
                            state_next = S_ALLOC_WAIT;
                        end
                    end
                    CMD_DEL_HEAD, CMD_DEL_TAIL:
                    begin
                        if (head_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            p_next     = head_reg;
                            q_next     = '0;
                            rd_en      = 1'b1;
                            rd_idx     = to_idx(head_reg);
                            state_next = (cmd_reg == CMD_DEL_HEAD) ? S_DHEAD_WAIT : S_WALK;
                        end
                    end
                    CMD_SEARCH, CMD_PRED, CMD_MEMBER:
                    begin
                        if (head_reg != '0)
                        begin
                            p_next     = head_reg;
                            q_next     = '0;
                            rd_en      = 1'b1;
                            rd_idx     = to_idx(head_reg);
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_ALLOC_WAIT:
            begin
                free_next = lnk;
                lnk_we    = 1'b1;
                lnk_widx  = to_idx(new_reg);
                if (cmd_reg == CMD_INS_HEAD || head_reg == '0)
                begin
                    lnk_wdata  = head_reg;
                    head_next  = new_reg;
                    res_next   = '{status: ST_OK, value_out: '0, address_out: new_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    // new node becomes the tail; go find the old one
                    lnk_wdata  = '0;
                    p_next     = head_reg;
                    rd_en      = 1'b1;
                    rd_idx     = to_idx(head_reg);
                    state_next = S_WALK;
                end
            end

            S_DHEAD_WAIT:
            begin
                head_next  = lnk;
                res_next   = '{status: ST_OK, value_out: val_rd_reg, address_out: '0};
                state_next = S_FREE;
            end

            S_FREE:
            begin
                // removed node goes to the head of the free list
                lnk_we     = 1'b1;
                lnk_widx   = to_idx(p_reg);
                lnk_wdata  = free_reg;
                free_next  = p_reg;
                state_next = S_DONE;
            end

            S_WALK:
            begin
                // lnk and val_rd_reg belong to p_reg
                if (cmd_reg inside {CMD_INS_TAIL, CMD_DEL_TAIL} && lnk == '0)
                begin
                    if (cmd_reg == CMD_INS_TAIL)
                    begin
                        lnk_we     = 1'b1;
                        lnk_widx   = to_idx(p_reg);
                        lnk_wdata  = new_reg;
                        res_next   = '{status: ST_OK, value_out: '0, address_out: new_reg};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (q_reg == '0)
                        begin
                            head_next = '0;
                        end
                        else
                        begin
                            lnk_we    = 1'b1;
                            lnk_widx  = to_idx(q_reg);
                            lnk_wdata = '0;
                        end
                        res_next   = '{status: ST_OK, value_out: val_rd_reg, address_out: '0};
                        state_next = S_FREE;
                    end
                end
                else if ((cmd_reg inside {CMD_SEARCH, CMD_PRED} && val_rd_reg == x_reg) ||
                         (cmd_reg == CMD_MEMBER && p_reg == taddr_reg))
                begin
                    res_next.status      = ST_OK;
                    res_next.value_out   = '0;
                    res_next.address_out = (cmd_reg == CMD_PRED) ? q_reg : p_reg;
                    state_next           = S_DONE;
                end
                else if (lnk == '0)
                begin
                    // end of list, nothing matched (res already holds a miss)
                    state_next = S_DONE;
                end
                else
                begin
                    q_next = p_reg;
                    p_next = lnk;
                    rd_en  = 1'b1;
                    rd_idx = to_idx(lnk);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_item_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            free_reg      <= ADDR_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        x_reg        <= x_next;
        taddr_reg    <= taddr_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        new_reg      <= new_next;
        res_reg      <= res_next;
        rsp_item_reg <= rsp_item_next;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

`default_nettype wire

@@ sv/alle_chk.sv @@
// Port-level checker for the array linked list engine, bound to the top.
// Depends on alle_pkg and array_linked_list_engine_top.
`timescale 1ns / 1ps
`default_nettype none

module alle_chk
    import alle_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_ready,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire rsp_item_t rsp_item
);

    // commands transferred whose result has not yet transferred
    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd_valid && cmd_ready)
        begin
            pend_next = pend_next + 2'd1;
        end
        if (rsp_valid && rsp_ready)
        begin
            pend_next = pend_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("result changed or dropped while stalled");

    a_no_third: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !cmd_ready)
        else $error("command taken with two results outstanding");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result without a command");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status != ST_OK |->
            rsp_item.value_out == '0 && rsp_item.address_out == '0)
        else $error("failed command returned data");

    a_del_nil: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.value_out != '0 |->
            rsp_item.status == ST_OK && rsp_item.address_out == '0)
        else $error("delete result carries an address");

endmodule

bind array_linked_list_engine_top alle_chk u_alle_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
);

`default_nettype wire
